[design/one_wire_bus_master_macros.svh]
`ifndef ONE_WIRE_BUS_MASTER_MACROS_SVH
`define ONE_WIRE_BUS_MASTER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define OWBM_ASSERT_NOW(label, cond, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (expr)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define OWBM_ASSERT_NEXT(label, cond, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

[design/owbm_pkg.sv]
`default_nettype none

package owbm_pkg;

    localparam int LONG_TIME_W  = 10;
    localparam int SHORT_TIME_W = 7;
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 10;

    localparam logic [1:0] ACT_NONE  = 2'd0;
    localparam logic [1:0] ACT_RESET = 2'd1;
    localparam logic [1:0] ACT_WRITE = 2'd2;
    localparam logic [1:0] ACT_READ  = 2'd3;

    localparam logic [CFG_INDEX_W-1:0] CFG_RESET_LOW     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PRESENCE_WAIT = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_RESET_TAIL    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SLOT_LOW      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_READ_SAMPLE   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_READ_TAIL     = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_WRITE0_LOW    = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_WRITE1_TAIL   = 3'd7;

    localparam logic [LONG_TIME_W-1:0]  RST_RESET_LOW     = 10'd480;
    localparam logic [LONG_TIME_W-1:0]  RST_PRESENCE_WAIT = 10'd80;
    localparam logic [LONG_TIME_W-1:0]  RST_RESET_TAIL    = 10'd400;
    localparam logic [SHORT_TIME_W-1:0] RST_SLOT_LOW      = 7'd5;
    localparam logic [SHORT_TIME_W-1:0] RST_READ_SAMPLE   = 7'd15;
    localparam logic [SHORT_TIME_W-1:0] RST_READ_TAIL     = 7'd40;
    localparam logic [SHORT_TIME_W-1:0] RST_WRITE0_LOW    = 7'd60;
    localparam logic [SHORT_TIME_W-1:0] RST_WRITE1_TAIL   = 7'd60;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_RST_LOW  = 4'd1,
        PH_RST_WAIT = 4'd2,
        PH_RST_TAIL = 4'd3,
        PH_RD_LOW   = 4'd4,
        PH_RD_WAIT  = 4'd5,
        PH_RD_TAIL  = 4'd6,
        PH_WR_LOW   = 4'd7,
        PH_WR_TAIL  = 4'd8
    } t_phase;

    typedef struct packed {
        logic [LONG_TIME_W-1:0]  reset_low_time;
        logic [LONG_TIME_W-1:0]  presence_wait_time;
        logic [LONG_TIME_W-1:0]  reset_tail_time;
        logic [SHORT_TIME_W-1:0] slot_low_time;
        logic [SHORT_TIME_W-1:0] read_sample_time;
        logic [SHORT_TIME_W-1:0] read_tail_time;
        logic [SHORT_TIME_W-1:0] write_zero_low_time;
        logic [SHORT_TIME_W-1:0] write_one_tail_time;
    } t_timing;

    typedef struct packed {
        logic       tick;
        logic [1:0] action;
        logic [7:0] write_byte;
        logic       line_level;
    } t_item;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic       presence;
        logic [7:0] read_byte;
    } t_result;

endpackage

`default_nettype wire

[design/owbm_if.sv]
`default_nettype none

interface owbm_item_if;
    logic       valid;
    logic       ready;
    logic       tick;
    logic [1:0] action;
    logic [7:0] write_byte;
    logic       line_level;

    modport source (output valid, output tick, output action, output write_byte,
                    output line_level, input ready);
    modport sink   (input valid, input tick, input action, input write_byte,
                    input line_level, output ready);
endinterface

interface owbm_result_if;
    logic       valid;
    logic       ready;
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       presence;
    logic [7:0] read_byte;

    modport source (output valid, output drive_low, output busy_res, output done_res,
                    output presence, output read_byte, input ready);
    modport sink   (input valid, input drive_low, input busy_res, input done_res,
                    input presence, input read_byte, output ready);
endinterface

interface owbm_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] index;
    logic [9:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[design/owbm_cfg.sv]
`default_nettype none

module owbm_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_wr_en,
    input  logic [owbm_pkg::CFG_INDEX_W-1:0]  i_wr_index,
    input  logic [owbm_pkg::CFG_DATA_W-1:0]   i_wr_data,
    output owbm_pkg::t_timing                 o_timing
);
    import owbm_pkg::*;

    t_timing r_timing;
    t_timing n_timing;

    always_comb begin
        n_timing = r_timing;
        if (i_wr_en) begin
            case (i_wr_index)
                CFG_RESET_LOW:     n_timing.reset_low_time      = i_wr_data[LONG_TIME_W-1:0];
                CFG_PRESENCE_WAIT: n_timing.presence_wait_time  = i_wr_data[LONG_TIME_W-1:0];
                CFG_RESET_TAIL:    n_timing.reset_tail_time     = i_wr_data[LONG_TIME_W-1:0];
                CFG_SLOT_LOW:      n_timing.slot_low_time       = i_wr_data[SHORT_TIME_W-1:0];
                CFG_READ_SAMPLE:   n_timing.read_sample_time    = i_wr_data[SHORT_TIME_W-1:0];
                CFG_READ_TAIL:     n_timing.read_tail_time      = i_wr_data[SHORT_TIME_W-1:0];
                CFG_WRITE0_LOW:    n_timing.write_zero_low_time = i_wr_data[SHORT_TIME_W-1:0];
                CFG_WRITE1_TAIL:   n_timing.write_one_tail_time = i_wr_data[SHORT_TIME_W-1:0];
                default:           n_timing = r_timing;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timing.reset_low_time      <= RST_RESET_LOW;
            r_timing.presence_wait_time  <= RST_PRESENCE_WAIT;
            r_timing.reset_tail_time     <= RST_RESET_TAIL;
            r_timing.slot_low_time       <= RST_SLOT_LOW;
            r_timing.read_sample_time    <= RST_READ_SAMPLE;
            r_timing.read_tail_time      <= RST_READ_TAIL;
            r_timing.write_zero_low_time <= RST_WRITE0_LOW;
            r_timing.write_one_tail_time <= RST_WRITE1_TAIL;
        end else begin
            r_timing <= n_timing;
        end
    end

    assign o_timing = r_timing;

endmodule

`default_nettype wire

[design/owbm_ctrl.sv]
`default_nettype none
`include "one_wire_bus_master_macros.svh"

module owbm_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  owbm_pkg::t_item    i_item,
    input  owbm_pkg::t_timing  i_timing,
    output owbm_pkg::t_result  o_result
);
    import owbm_pkg::*;

    t_phase                 r_phase;
    t_phase                 n_phase;
    logic [LONG_TIME_W-1:0] r_count;
    logic [LONG_TIME_W-1:0] n_count;
    logic [2:0]             r_bit;
    logic [2:0]             n_bit;
    logic [1:0]             r_kind;
    logic [1:0]             n_kind;
    logic [7:0]             r_shift;
    logic [7:0]             n_shift;
    logic                   r_presence;
    logic                   n_presence;

    logic [LONG_TIME_W-1:0] limit;
    logic [LONG_TIME_W-1:0] count_inc;
    logic                   done;
    logic                   last_bit;

    // The count saturates so a very long phase never wraps back below its limit.
    assign count_inc = (i_item.tick && (r_count != '1)) ? r_count + 1'b1 : r_count;
    assign last_bit  = (r_bit == 3'd7);

    always_comb begin
        case (r_phase)
            PH_RST_LOW:  limit = i_timing.reset_low_time;
            PH_RST_WAIT: limit = i_timing.presence_wait_time;
            PH_RST_TAIL: limit = i_timing.reset_tail_time;
            PH_RD_LOW:   limit = LONG_TIME_W'(i_timing.slot_low_time);
            PH_RD_WAIT:  limit = LONG_TIME_W'(i_timing.read_sample_time);
            PH_RD_TAIL:  limit = LONG_TIME_W'(i_timing.read_tail_time);
            PH_WR_LOW:   limit = r_shift[0] ? LONG_TIME_W'(i_timing.slot_low_time)
                                            : LONG_TIME_W'(i_timing.write_zero_low_time);
            PH_WR_TAIL:  limit = LONG_TIME_W'(i_timing.write_one_tail_time);
            default:     limit = '0;
        endcase
    end

    always_comb begin
        n_phase    = r_phase;
        n_count    = r_count;
        n_bit      = r_bit;
        n_kind     = r_kind;
        n_shift    = r_shift;
        n_presence = r_presence;
        done       = 1'b0;
        if (r_phase == PH_IDLE) begin
            if (i_item.action != ACT_NONE) begin
                n_kind  = i_item.action;
                n_bit   = '0;
                n_count = '0;
                case (i_item.action)
                    ACT_RESET: begin
                        n_presence = 1'b0;
                        n_phase    = PH_RST_LOW;
                    end
                    ACT_WRITE: begin
                        n_shift = i_item.write_byte;
                        n_phase = PH_WR_LOW;
                    end
                    default: begin
                        n_shift = '0;
                        n_phase = PH_RD_LOW;
                    end
                endcase
            end
        end else if (count_inc >= limit) begin
            n_count = '0;
            case (r_phase)
                PH_RST_LOW:  n_phase = PH_RST_WAIT;
                PH_RST_WAIT: begin
                    n_presence = ~i_item.line_level;
                    n_phase    = PH_RST_TAIL;
                end
                PH_RST_TAIL: done = 1'b1;
                PH_RD_LOW:   n_phase = PH_RD_WAIT;
                PH_RD_WAIT: begin
                    n_shift = {i_item.line_level, r_shift[7:1]};
                    n_phase = PH_RD_TAIL;
                end
                PH_RD_TAIL: begin
                    if (last_bit) begin
                        done = 1'b1;
                    end else begin
                        n_bit   = r_bit + 1'b1;
                        n_phase = PH_RD_LOW;
                    end
                end
                PH_WR_LOW: begin
                    // A zero slot runs straight into the next slot, no recovery.
                    if (r_shift[0]) begin
                        n_phase = PH_WR_TAIL;
                    end else begin
                        n_shift = {1'b0, r_shift[7:1]};
                        if (last_bit) begin
                            done = 1'b1;
                        end else begin
                            n_bit   = r_bit + 1'b1;
                            n_phase = PH_WR_LOW;
                        end
                    end
                end
                PH_WR_TAIL: begin
                    n_shift = {1'b0, r_shift[7:1]};
                    if (last_bit) begin
                        done = 1'b1;
                    end else begin
                        n_bit   = r_bit + 1'b1;
                        n_phase = PH_WR_LOW;
                    end
                end
                default: done = 1'b1;
            endcase
            if (done) begin
                n_phase = PH_IDLE;
            end
        end else begin
            n_count = count_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_count    <= '0;
            r_bit      <= '0;
            r_kind     <= ACT_NONE;
            r_shift    <= '0;
            r_presence <= 1'b0;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_count    <= n_count;
            r_bit      <= n_bit;
            r_kind     <= n_kind;
            r_shift    <= n_shift;
            r_presence <= n_presence;
        end
    end

    always_comb begin
        o_result.drive_low = (n_phase == PH_RST_LOW) || (n_phase == PH_RD_LOW)
                             || (n_phase == PH_WR_LOW);
        o_result.busy_res  = (n_phase != PH_IDLE);
        o_result.done_res  = done;
        o_result.presence  = (done && (n_kind == ACT_RESET)) ? n_presence : 1'b0;
        o_result.read_byte = (done && (n_kind == ACT_READ)) ? n_shift : 8'd0;
    end

    `OWBM_ASSERT_NOW(a_idle_count_clear, r_phase == PH_IDLE, r_count == '0, "count not clear in idle")
    `OWBM_ASSERT_NEXT(a_hold_without_step, !i_step, $stable(r_phase) && $stable(r_count), "state moved without a beat")
    `OWBM_ASSERT_NEXT(a_done_to_idle, i_step && done, r_phase == PH_IDLE, "completion did not return to idle")

endmodule

`default_nettype wire

[design/owbm_outbuf.sv]
`default_nettype none
`include "one_wire_bus_master_macros.svh"

module owbm_outbuf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  owbm_pkg::t_result  i_result,
    owbm_result_if.source      o_res
);
    import owbm_pkg::*;

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    take;
    logic    out_free;

    assign take     = o_res.valid && o_res.ready;
    assign out_free = !r_out_valid || take;
    assign o_ready  = !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_free) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (out_free) begin
            r_out_valid <= i_valid;
        end else if (i_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    // The held beat always leaves before a new one is taken in.
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_free) begin
                r_out <= r_skid;
            end
        end else if (out_free) begin
            r_out <= i_result;
        end else begin
            r_skid <= i_result;
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.drive_low = r_out.drive_low;
    assign o_res.busy_res  = r_out.busy_res;
    assign o_res.done_res  = r_out.done_res;
    assign o_res.presence  = r_out.presence;
    assign o_res.read_byte = r_out.read_byte;

    `OWBM_ASSERT_NOW(a_skid_implies_out, r_skid_valid, r_out_valid, "skid holds a beat ahead of output")
    `OWBM_ASSERT_NEXT(a_stall_fills_skid, i_valid && o_ready && r_out_valid && !o_res.ready, r_skid_valid, "stalled beat was dropped")
    `OWBM_ASSERT_NEXT(a_skid_drains, r_skid_valid && o_res.ready, !r_skid_valid && r_out_valid, "skid did not drain")

endmodule

`default_nettype wire

[design/one_wire_bus_master.sv]
// One-wire bus master. Each beat on i_cmd is one clock of bus time: an optional
// one-microsecond tick, a command (none, bus reset, write byte, read byte), the byte
// to write and the sampled line level. Every accepted beat yields exactly one beat
// on o_res, with the line drive and busy state after that beat, a one-beat done
// flag, and the presence flag or received byte alongside done. One command beat is
// taken every clock while i_cmd is ready; the state machine updates in the clock
// that takes the beat, and a two-entry output buffer lets one more beat in while
// o_res is stalled, so i_cmd.ready drops only after a second result is waiting.
// Timing registers 0 to 7 are written on i_cfg, which is always ready, and should be
// written only while the master is idle. Commands given while busy are ignored.
`default_nettype none

module one_wire_bus_master (
    input  logic          i_clk,
    input  logic          i_rst_n,
    owbm_item_if.sink     i_cmd,
    owbm_cfg_if.sink      i_cfg,
    owbm_result_if.source o_res
);
    import owbm_pkg::*;

    t_timing timing;
    t_item   item;
    t_result result;
    logic    step;
    logic    buf_ready;

    assign item.tick       = i_cmd.tick;
    assign item.action     = i_cmd.action;
    assign item.write_byte = i_cmd.write_byte;
    assign item.line_level = i_cmd.line_level;

    assign i_cmd.ready = buf_ready;
    assign step        = i_cmd.valid && buf_ready;
    assign i_cfg.ready = 1'b1;

    owbm_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg.valid),
        .i_wr_index (i_cfg.index),
        .i_wr_data  (i_cfg.data),
        .o_timing   (timing)
    );

    owbm_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (item),
        .i_timing (timing),
        .o_result (result)
    );

    owbm_outbuf u_outbuf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (step),
        .o_ready  (buf_ready),
        .i_result (result),
        .o_res    (o_res)
    );

endmodule

`default_nettype wire
